/* sv/nks_pkg.sv */
package nks_pkg;

	// window and keyword list sizes
	localparam int WINDOW_LEN   = 6;
	localparam int NUM_WORDS    = 28;
	localparam int TABLE_WORDS  = 28;
	localparam int MAX_WORD     = 8;
	localparam int ACTIVE_WORDS = (NUM_WORDS < TABLE_WORDS) ? NUM_WORDS : TABLE_WORDS;
	localparam int DIST_W       = $clog2(WINDOW_LEN);
	localparam int WIDX_W       = $clog2(TABLE_WORDS);
	localparam int LEN_W        = $clog2(MAX_WORD + 1);

	// keyword entry: text right-justified, newest (last) character in the low byte
	typedef struct packed {
		logic [LEN_W-1:0]      len;
		logic [MAX_WORD*8-1:0] text;
	} kw_entry_t;

	// per-cycle control handed to every cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic kw_entry_t kw_entry(input logic [WIDX_W-1:0] idx);
		kw_entry_t e;
		e.len  = '0;
		e.text = '0;
		unique case (idx)
			5'd0:  begin e.len = LEN_W'(2); e.text = (MAX_WORD*8)'("sv");     end
			5'd1:  begin e.len = LEN_W'(4); e.text = (MAX_WORD*8)'("game");   end
			5'd2:  begin e.len = LEN_W'(4); e.text = (MAX_WORD*8)'("hack");   end
			5'd3:  begin e.len = LEN_W'(2); e.text = (MAX_WORD*8)'("gm");     end
			5'd4:  begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("admin");  end
			5'd5:  begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("wow");    end
			5'd6:  begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("www");    end
			5'd7:  begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("realm");  end
			5'd8:  begin e.len = LEN_W'(2); e.text = (MAX_WORD*8)'("ip");     end
			5'd9:  begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("event");  end
			5'd10: begin e.len = LEN_W'(6); e.text = (MAX_WORD*8)'("server"); end
			5'd11: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("bug");    end
			5'd12: begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("cheat");  end
			5'd13: begin e.len = LEN_W'(6); e.text = (MAX_WORD*8)'("gaming"); end
			5'd14: begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("guild");  end
			5'd15: begin e.len = LEN_W'(6); e.text = (MAX_WORD*8)'("change"); end
			5'd16: begin e.len = LEN_W'(4); e.text = (MAX_WORD*8)'("site");   end
			5'd17: begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("level");  end
			5'd18: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("lvl");    end
			5'd19: begin e.len = LEN_W'(6); e.text = (MAX_WORD*8)'("ticket"); end
			5'd20: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("335");    end
			5'd21: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("434");    end
			5'd22: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("548");    end
			5'd23: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("735");    end
			5'd24: begin e.len = LEN_W'(3); e.text = (MAX_WORD*8)'("neo");    end
			5'd25: begin e.len = LEN_W'(6); e.text = (MAX_WORD*8)'("harmez"); end
			5'd26: begin e.len = LEN_W'(2); e.text = (MAX_WORD*8)'("sv");     end
			5'd27: begin e.len = LEN_W'(5); e.text = (MAX_WORD*8)'("siren");  end
			default: begin e.len = '0; e.text = '0; end
		endcase
		return e;
	endfunction

endpackage

/* sv/nks_cell.sv */
module nks_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nks_pkg::cell_ctrl_t                 ctrl,
	input  logic [nks_pkg::DIST_W-1:0]          slot,
	input  logic [7:0]                          nxt_char,
	input  logic                                nxt_valid,
	output logic [7:0]                          cur_char,
	output logic                                cur_valid,
	output logic [nks_pkg::ACTIVE_WORDS-1:0]    word_ok
);

	logic [7:0] char_q;
	logic       valid_q;

	// character payload, taken from the newer neighbour on a shift
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			char_q <= nxt_char;
		end
	end

	// occupancy bit, cleared at the end of each message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nxt_valid;
		end
	end

	assign cur_char  = char_q;
	assign cur_valid = valid_q;

	// per-keyword compare of the character this cell holds after the shift
	always_comb begin
		nks_pkg::kw_entry_t ent;
		logic [7:0]         want;
		for (int w = 0; w < nks_pkg::ACTIVE_WORDS; w++) begin
			ent  = nks_pkg::kw_entry(nks_pkg::WIDX_W'(w));
			want = 8'h00;
			for (int k = 0; k < nks_pkg::MAX_WORD; k++) begin
				if (int'(slot) == k) begin
					want = ent.text[8*k +: 8];
				end
			end
			if (int'(slot) < int'(ent.len)) begin
				word_ok[w] = nxt_valid && (nxt_char == want);
			end else begin
				word_ok[w] = 1'b1;
			end
		end
	end

endmodule

/* sv/normalized_keyword_spotter_unit.sv */
// channel   dir  tdata                       tuser     tlast
// s_axis    in   [7:0] char_byte             exempt    last_of_message
// m_axis    out  [0] flagged, [7:1] zero     -         -
//
// one byte per cycle while s_axis_tready is high; the window shift and all keyword
// compares finish in the cycle a byte is taken, since the cell row compare is combinational
// the result of a message is registered and appears on m_axis in the cycle after its last byte is taken
// reset clears the cell occupancy bits, the sticky hit and the output valid bit
// s_axis_tready drops only while a result waits and m_axis_tready is low
module normalized_keyword_spotter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
	input  logic       s_axis_tlast,
	input  logic       s_axis_tuser,   // [0] exempt
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] flagged, [7:1] zero
);

	localparam int WL = nks_pkg::WINDOW_LEN;
	localparam int AW = nks_pkg::ACTIVE_WORDS;

	logic                in_xfer;
	logic                alnum;
	logic [7:0]          lc_char;
	logic                dup;
	logic                match;
	logic                hit_q;
	logic                out_vld_q;
	logic                flagged_q;
	nks_pkg::cell_ctrl_t ctrl;

	logic [7:0]    cell_char  [WL];
	logic          cell_valid [WL];
	logic [7:0]    feed_char  [WL];
	logic          feed_valid [WL];
	logic [AW-1:0] cell_ok    [WL];

	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// keep letters and digits, fold to lower case
	always_comb begin
		alnum   = ((s_axis_tdata >= 8'h30) && (s_axis_tdata <= 8'h39)) ||
		          ((s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h5a)) ||
		          ((s_axis_tdata >= 8'h61) && (s_axis_tdata <= 8'h7a));
		lc_char = s_axis_tdata;
		if ((s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h5a)) begin
			lc_char = s_axis_tdata + 8'd32;
		end
	end

	// repeated character is dropped
	assign dup = cell_valid[0] && (cell_char[0] == lc_char);

	assign ctrl.shift = in_xfer && alnum && !dup;
	assign ctrl.clear = in_xfer && s_axis_tlast;

	// neighbour feeds: newest cell takes the normalised byte
	always_comb begin
		feed_char[0]  = lc_char;
		feed_valid[0] = 1'b1;
		for (int d = 1; d < WL; d++) begin
			feed_char[d]  = cell_char[d-1];
			feed_valid[d] = cell_valid[d-1];
		end
	end

	// row of window cells, distance 0 holds the newest character
	for (genvar d = 0; d < WL; d++) begin : g_cell
		nks_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.slot      (nks_pkg::DIST_W'(d)),
			.nxt_char  (feed_char[d]),
			.nxt_valid (feed_valid[d]),
			.cur_char  (cell_char[d]),
			.cur_valid (cell_valid[d]),
			.word_ok   (cell_ok[d])
		);
	end

	// keyword hit: every cell agrees and the keyword fits the window
	always_comb begin
		nks_pkg::kw_entry_t ent;
		logic               all_ok;
		match = 1'b0;
		for (int w = 0; w < AW; w++) begin
			ent    = nks_pkg::kw_entry(nks_pkg::WIDX_W'(w));
			all_ok = (int'(ent.len) >= 1) && (int'(ent.len) <= WL);
			for (int d = 0; d < WL; d++) begin
				all_ok = all_ok && cell_ok[d][w];
			end
			match = match || all_ok;
		end
	end

	// sticky hit, cleared with the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (in_xfer) begin
			if (s_axis_tlast) begin
				hit_q <= 1'b0;
			end else if (ctrl.shift && match) begin
				hit_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_xfer && s_axis_tlast) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_axis_tlast) begin
			flagged_q <= (hit_q || (ctrl.shift && match)) && !s_axis_tuser;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, flagged_q};

`ifndef NO_ASSERTIONS
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast |=> m_axis_tvalid)
		else $error("no result after last byte");

	a_hit_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast |=> !hit_q)
		else $error("sticky hit survived end of message");

	a_exempt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast && s_axis_tuser |=> !m_axis_tdata[0])
		else $error("exempt message flagged");

	a_window_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && s_axis_tlast |=> !cell_valid[0])
		else $error("window not cleared after message");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a waiting result");
`endif

endmodule
